// File: src/ddo_pkg.sv
// Shared widths, codes, types and the sine table of the odometry block.
`timescale 1ns / 1ps

package ddo_pkg;

   // Field widths
   localparam int COUNT_BITS   = 24;
   localparam int SUM_BITS     = COUNT_BITS + 1;
   localparam int MPT_BITS     = 24;
   localparam int POS_BITS     = 32;
   localparam int HEADING_BITS = 7;
   localparam int CMD_BITS     = 2;

   localparam logic [MPT_BITS-1:0] MPT_RESET = MPT_BITS'(64281);

   // Heading circle: 1/128 turn per step, quarter turn is 32 steps
   localparam int HEADING_STEPS = 1 << HEADING_BITS;
   localparam int QUARTER_BITS  = HEADING_BITS - 2;
   localparam int QUARTER_STEPS = HEADING_STEPS / 4;
   localparam int TRIG_BITS     = 17;

   // Datapath widths
   localparam int PROD_BITS   = SUM_BITS + MPT_BITS;
   localparam int DIST_SHIFT  = 9;
   localparam int DIST_BITS   = PROD_BITS - DIST_SHIFT;
   localparam int SLICE_BITS  = DIST_BITS / 2;
   localparam int ACC_BITS    = DIST_BITS + TRIG_BITS + 1;
   localparam int ROUND_SHIFT = 16;
   localparam int STEP_BITS   = ACC_BITS - ROUND_SHIFT;
   localparam int WIDE_BITS   = STEP_BITS + 2;

   localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (ROUND_SHIFT - 1);

   // Item kinds
   localparam logic ACTION_SAMPLE  = 1'b0;
   localparam logic ACTION_COMMAND = 1'b1;

   // Motion modes
   localparam logic [CMD_BITS-1:0] CMD_FORWARD = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_LEFT    = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RIGHT   = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_STOP    = 2'd3;

   // Pending work
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_MOVE = 2'd1;
   localparam logic [1:0] PEND_TURN = 2'd2;

   typedef struct packed {
      logic                 neg;
      logic [TRIG_BITS-1:0] mag;
   } trig_type;

   // sin(m * pi / 64) in Q16, m = 0..32, rounded half up
   function automatic logic [TRIG_BITS-1:0] quarter_sine(input logic [QUARTER_BITS:0] m);
      logic [TRIG_BITS-1:0] v;
      case (m)
         6'd0:    v = 17'd0;
         6'd1:    v = 17'd3216;
         6'd2:    v = 17'd6424;
         6'd3:    v = 17'd9616;
         6'd4:    v = 17'd12785;
         6'd5:    v = 17'd15924;
         6'd6:    v = 17'd19024;
         6'd7:    v = 17'd22078;
         6'd8:    v = 17'd25080;
         6'd9:    v = 17'd28020;
         6'd10:   v = 17'd30893;
         6'd11:   v = 17'd33692;
         6'd12:   v = 17'd36410;
         6'd13:   v = 17'd39040;
         6'd14:   v = 17'd41576;
         6'd15:   v = 17'd44011;
         6'd16:   v = 17'd46341;
         6'd17:   v = 17'd48559;
         6'd18:   v = 17'd50660;
         6'd19:   v = 17'd52639;
         6'd20:   v = 17'd54491;
         6'd21:   v = 17'd56212;
         6'd22:   v = 17'd57798;
         6'd23:   v = 17'd59244;
         6'd24:   v = 17'd60547;
         6'd25:   v = 17'd61705;
         6'd26:   v = 17'd62714;
         6'd27:   v = 17'd63572;
         6'd28:   v = 17'd64277;
         6'd29:   v = 17'd64827;
         6'd30:   v = 17'd65221;
         6'd31:   v = 17'd65457;
         6'd32:   v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // Sine of a heading index as sign and magnitude (quadrant folding)
   function automatic trig_type trig_lookup(input logic [HEADING_BITS-1:0] idx);
      trig_type                t;
      logic [QUARTER_BITS:0]   r;
      logic [QUARTER_BITS:0]   m;
      r = {1'b0, idx[QUARTER_BITS-1:0]};
      m = idx[QUARTER_BITS] ? ((QUARTER_BITS+1)'(QUARTER_STEPS) - r) : r;
      t.neg = idx[HEADING_BITS-1];
      t.mag = quarter_sine(m);
      return t;
   endfunction

endpackage

// File: src/ddo_channels.sv
// Valid/ready channel interfaces for sample/command items, pose results and the scale register.
`timescale 1ns / 1ps

interface ddo_req_if;
   import ddo_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [COUNT_BITS-1:0] left_count;
   logic [COUNT_BITS-1:0] right_count;
   logic [CMD_BITS-1:0]   command;

   modport source (output valid, action, left_count, right_count, command, input ready);
   modport sink   (input valid, action, left_count, right_count, command, output ready);
endinterface

interface ddo_rsp_if;
   import ddo_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [POS_BITS-1:0]     pos_x;
   logic signed [POS_BITS-1:0]     pos_y;
   logic        [HEADING_BITS-1:0] heading;
   logic                           updated;

   modport source (output valid, pos_x, pos_y, heading, updated, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, updated, output ready);
endinterface

interface ddo_csr_if;
   import ddo_pkg::*;
   logic                valid;
   logic                ready;
   logic [MPT_BITS-1:0] metres_per_tick;

   modport source (output valid, metres_per_tick, input ready);
   modport sink   (input valid, metres_per_tick, output ready);
endinterface

// File: src/diff_drive_odometry_unit.sv
// Two-wheel dead-reckoning pose tracker: mode sequencing, shared multiplier, pose registers.
`timescale 1ns / 1ps

// Each accepted item returns one pose item (x, y in 2^-16 m, heading in 1/128 turn). Commands,
// samples that only latch a move or turn or find nothing pending, and samples that apply a turn
// go from the accept straight to loading the result register. A sample that applies a pending
// move first uses the single 25x24 multiplier for one distance product, then for two partial
// products (low and high half of the distance) per axis; the high one is added onto the low one
// with rounding, then a saturating position add follows. The block takes one item at a
// time. The last cycle of an item repeats for as long as the previous pose item still waits
// on the result channel. The block is ready again as soon as the result register is loaded,
// even if that result has not been taken yet. The metres_per_tick register is always ready;
// write it only while the block is idle.
module diff_drive_odometry_unit (
   input  logic       clock,
   input  logic       reset,
   ddo_req_if.sink    req_bus,
   ddo_rsp_if.source  rsp_bus,
   ddo_csr_if.sink    csr_bus
);
   import ddo_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIST = 3'd1;
   localparam logic [2:0] ST_LO   = 3'd2;
   localparam logic [2:0] ST_HI   = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [MPT_BITS-1:0]            mpt_ff, mpt_in;
   logic [CMD_BITS-1:0]            mode_ff, mode_in;
   logic [1:0]                     pending_ff, pending_in;
   logic [SUM_BITS-1:0]            prev_sum_ff, prev_sum_in;
   logic [HEADING_BITS-1:0]        arc_ff, arc_in;
   logic [HEADING_BITS-1:0]        heading_ff, heading_in;
   logic signed [POS_BITS-1:0]     pos_x_ff, pos_x_in;
   logic signed [POS_BITS-1:0]     pos_y_ff, pos_y_in;
   logic                           axis_ff, axis_in;
   logic                           upd_ff, upd_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Datapath payload registers
   logic [SUM_BITS-1:0]            mag_ff, mag_in;
   logic                           delta_neg_ff, delta_neg_in;
   logic [DIST_BITS-1:0]           dist_ff, dist_in;
   trig_type                       trig_ff, trig_in;
   logic [ACC_BITS-1:0]            acc_ff, acc_in;
   logic signed [POS_BITS-1:0]     rsp_x_ff, rsp_x_in;
   logic signed [POS_BITS-1:0]     rsp_y_ff, rsp_y_in;
   logic [HEADING_BITS-1:0]        rsp_heading_ff, rsp_heading_in;
   logic                           rsp_updated_ff, rsp_updated_in;

   // Sum delta and turn arc
   logic [SUM_BITS-1:0]            cur_sum;
   logic [SUM_BITS-1:0]            delta;
   logic [SUM_BITS:0]              delta_ext;
   logic [SUM_BITS:0]              arc_src;
   logic [SUM_BITS:0]              arc_trunc;
   logic [HEADING_BITS-1:0]        arc_bits;

   // Shared multiplier
   logic [SUM_BITS-1:0]            mul_a;
   logic [MPT_BITS-1:0]            mul_b;
   logic [PROD_BITS-1:0]           prod;
   logic [ACC_BITS-1:0]            prod_wide;

   // Position update
   logic [STEP_BITS-1:0]           step;
   logic                           step_neg;
   logic signed [POS_BITS-1:0]     pos_cur;
   logic [WIDE_BITS-1:0]           pos_wide;
   logic [WIDE_BITS-1:0]           step_wide;
   logic [WIDE_BITS-1:0]           pos_sum;
   logic signed [POS_BITS-1:0]     pos_sat;
   logic                           rsp_free;

   assign req_bus.ready   = (state_ff == ST_IDLE);
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.pos_x   = rsp_x_ff;
   assign rsp_bus.pos_y   = rsp_y_ff;
   assign rsp_bus.heading = rsp_heading_ff;
   assign rsp_bus.updated = rsp_updated_ff;

   // Modular delta of wheel-count sums; arc is delta/2 (negated for a left turn) truncated toward zero
   always_comb begin
      cur_sum   = {1'b0, req_bus.left_count} + {1'b0, req_bus.right_count};
      delta     = cur_sum - prev_sum_ff;
      delta_ext = {delta[SUM_BITS-1], delta};
      arc_src   = (mode_ff == CMD_RIGHT) ? delta_ext : ((SUM_BITS+1)'(0) - delta_ext);
      arc_trunc = arc_src + {{SUM_BITS{1'b0}}, arc_src[SUM_BITS]};
      arc_bits  = arc_trunc[HEADING_BITS:1];
   end

   // One multiplier: distance product, then low and high partial products
   always_comb begin
      if (state_ff == ST_DIST) begin
         mul_a = mag_ff;
         mul_b = mpt_ff;
      end else if (state_ff == ST_HI) begin
         mul_a = SUM_BITS'(dist_ff[DIST_BITS-1:SLICE_BITS]);
         mul_b = MPT_BITS'(trig_ff.mag);
      end else begin
         mul_a = SUM_BITS'(dist_ff[SLICE_BITS-1:0]);
         mul_b = MPT_BITS'(trig_ff.mag);
      end
      prod      = {{MPT_BITS{1'b0}}, mul_a} * {{SUM_BITS{1'b0}}, mul_b};
      prod_wide = {{(ACC_BITS-PROD_BITS){1'b0}}, prod};
   end

   // Signed step onto the selected axis with saturation
   always_comb begin
      step      = acc_ff[ACC_BITS-1:ROUND_SHIFT];
      step_neg  = delta_neg_ff ^ trig_ff.neg;
      pos_cur   = axis_ff ? pos_y_ff : pos_x_ff;
      pos_wide  = {{(WIDE_BITS-POS_BITS){pos_cur[POS_BITS-1]}}, pos_cur};
      step_wide = {2'b00, step};
      pos_sum   = step_neg ? (pos_wide - step_wide) : (pos_wide + step_wide);
      if (pos_sum[WIDE_BITS-1:POS_BITS-1] == {(WIDE_BITS-POS_BITS+1){1'b0}} ||
          pos_sum[WIDE_BITS-1:POS_BITS-1] == {(WIDE_BITS-POS_BITS+1){1'b1}}) begin
         pos_sat = signed'(pos_sum[POS_BITS-1:0]);
      end else if (pos_sum[WIDE_BITS-1]) begin
         pos_sat = signed'({1'b1, {(POS_BITS-1){1'b0}}});
      end else begin
         pos_sat = signed'({1'b0, {(POS_BITS-1){1'b1}}});
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // Sequencer and pose update
   always_comb begin
      state_in       = state_ff;
      mpt_in         = mpt_ff;
      mode_in        = mode_ff;
      pending_in     = pending_ff;
      prev_sum_in    = prev_sum_ff;
      arc_in         = arc_ff;
      heading_in     = heading_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      axis_in        = axis_ff;
      upd_in         = upd_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      mag_in         = mag_ff;
      delta_neg_in   = delta_neg_ff;
      dist_in        = dist_ff;
      trig_in        = trig_ff;
      acc_in         = acc_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_updated_in = rsp_updated_ff;

      if (csr_bus.valid) begin
         mpt_in = csr_bus.metres_per_tick;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               upd_in   = 1'b0;
               state_in = ST_DONE;
               if (req_bus.action == ACTION_COMMAND) begin
                  mode_in = req_bus.command;
               end else begin
                  unique case (mode_ff) inside
                     CMD_RIGHT, CMD_LEFT: begin
                        arc_in     = arc_bits;
                        pending_in = PEND_TURN;
                     end
                     CMD_FORWARD: begin
                        pending_in = PEND_MOVE;
                     end
                     default: begin
                        // stop: apply what is pending
                        if (pending_ff == PEND_MOVE) begin
                           mag_in       = delta[SUM_BITS-1] ? (SUM_BITS'(0) - delta) : delta;
                           delta_neg_in = delta[SUM_BITS-1];
                           pending_in   = PEND_NONE;
                           prev_sum_in  = cur_sum;
                           upd_in       = 1'b1;
                           state_in     = ST_DIST;
                        end else if (pending_ff == PEND_TURN) begin
                           heading_in  = heading_ff + arc_ff;
                           pending_in  = PEND_NONE;
                           prev_sum_in = cur_sum;
                           upd_in      = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         ST_DIST: begin
            dist_in  = prod[PROD_BITS-1:DIST_SHIFT];
            trig_in  = trig_lookup(heading_ff);
            axis_in  = 1'b0;
            state_in = ST_LO;
         end
         ST_LO: begin
            acc_in   = prod_wide;
            state_in = ST_HI;
         end
         ST_HI: begin
            acc_in   = acc_ff + (prod_wide << SLICE_BITS) + ROUND_HALF;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (axis_ff) begin
               pos_y_in = pos_sat;
               state_in = ST_DONE;
            end else begin
               // x done with sine; y next with cosine (quarter turn ahead)
               pos_x_in = pos_sat;
               axis_in  = 1'b1;
               trig_in  = trig_lookup(heading_ff + HEADING_BITS'(QUARTER_STEPS));
               state_in = ST_LO;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_x_in       = pos_x_ff;
               rsp_y_in       = pos_y_ff;
               rsp_heading_in = heading_ff;
               rsp_updated_in = upd_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and pose registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mpt_ff       <= MPT_RESET;
         mode_ff      <= CMD_STOP;
         pending_ff   <= PEND_NONE;
         prev_sum_ff  <= '0;
         arc_ff       <= '0;
         heading_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         axis_ff      <= 1'b0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mpt_ff       <= mpt_in;
         mode_ff      <= mode_in;
         pending_ff   <= pending_in;
         prev_sum_ff  <= prev_sum_in;
         arc_ff       <= arc_in;
         heading_ff   <= heading_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         axis_ff      <= axis_in;
         upd_ff       <= upd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload
   always_ff @(posedge clock) begin
      mag_ff         <= mag_in;
      delta_neg_ff   <= delta_neg_in;
      dist_ff        <= dist_in;
      trig_ff        <= trig_in;
      acc_ff         <= acc_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_updated_ff <= rsp_updated_in;
   end

endmodule

// File: src/ddo_checker.sv
// Port-level assertions for the odometry block, bound to its top level.
`timescale 1ns / 1ps

module ddo_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [ddo_pkg::POS_BITS-1:0]     rsp_pos_x,
   input logic signed [ddo_pkg::POS_BITS-1:0]     rsp_pos_y,
   input logic        [ddo_pkg::HEADING_BITS-1:0] rsp_heading,
   input logic                                    rsp_updated
);
   import ddo_pkg::*;

   // Stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
                                  $stable(rsp_heading) && $stable(rsp_updated))
      else $error("result changed while stalled");

   // One item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous item in work");

   // Reset leaves the block idle with no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle and empty after reset");

   // A new result only appears at the end of an item's work
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without item in work");

endmodule

bind diff_drive_odometry_unit ddo_checker u_ddo_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_pos_x   (rsp_bus.pos_x),
   .rsp_pos_y   (rsp_bus.pos_y),
   .rsp_heading (rsp_bus.heading),
   .rsp_updated (rsp_bus.updated)
);

// File: tb/sv/ddo_pose_checker.sv
// Pose checker for the odometry unit: predicts each pose item and compares it with the block.
`timescale 1ns / 1ps

module ddo_pose_checker (
   input  logic clock,
   input  logic reset,
   ddo_req_if   req_bus,
   ddo_rsp_if   rsp_bus,
   ddo_csr_if   csr_bus,
   output int   mismatch_count,
   output int   backlog
);
   import ddo_pkg::*;

   typedef struct packed {
      logic signed [POS_BITS-1:0] x;
      logic signed [POS_BITS-1:0] y;
      logic [HEADING_BITS-1:0]    heading;
      logic                       updated;
   } pose_item_type;

   localparam longint unsigned Q30_UNIT   = 64'd1 << 30;
   localparam longint unsigned HALF_PI_Q  = 64'd1686629713;
   localparam longint          POS_TOP    = 64'sd2147483647;
   localparam longint          POS_BOTTOM = -64'sd2147483648;

   // Tracked pose and motion state
   logic [MPT_BITS-1:0]     scale;
   logic [CMD_BITS-1:0]     motion;
   logic [1:0]              queued_work;
   logic [SUM_BITS-1:0]     sum_now;
   logic [SUM_BITS-1:0]     sum_base;
   longint                  arc_steps;
   logic [HEADING_BITS-1:0] heading_idx;
   longint                  x_pos;
   longint                  y_pos;
   pose_item_type           expected_poses[$];

   // sin over a quarter turn, u in [0, 2^30] quarter-turn units, result Q30 (Taylor to x^9)
   function automatic longint unsigned quarter_sin_q30(input longint unsigned u);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      x  = (u * HALF_PI_Q) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_UNIT - x2 / 72;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 42;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 20;
      t  = Q30_UNIT - ((x2 * t) >> 30) / 6;
      return (x * t) >> 30;
   endfunction

   // sin of a full-circle angle (2^32 per turn) as signed Q16
   function automatic longint angle_sin_q16(input logic [31:0] a);
      longint unsigned rest;
      longint unsigned s;
      longint          v;
      rest = {34'd0, a[29:0]};
      s = a[30] ? quarter_sin_q30(Q30_UNIT - rest) : quarter_sin_q30(rest);
      v = longint'((s + 64'd8192) >> 14);
      return a[31] ? -v : v;
   endfunction

   // Position step on one axis: distance scaled by a trig factor, rounded, signed
   function automatic longint axis_step(input longint delta, input longint trig,
                                        input logic [MPT_BITS-1:0] mpt);
      longint unsigned mag;
      longint unsigned travel;
      longint unsigned tmag;
      longint unsigned s;
      mag    = (delta < 0) ? -delta : delta;
      travel = (mag * {40'd0, mpt}) >> 9;
      tmag   = (trig < 0) ? -trig : trig;
      s      = (travel * tmag + 64'd32768) >> 16;
      return ((delta < 0) != (trig < 0)) ? -longint'(s) : longint'(s);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > POS_TOP) return POS_TOP;
      if (v < POS_BOTTOM) return POS_BOTTOM;
      return v;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] pose check: %s, got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Apply one accepted item to the tracked pose and queue the pose it should produce
   task automatic advance_pose(input logic act, input logic [COUNT_BITS-1:0] l,
                               input logic [COUNT_BITS-1:0] r, input logic [CMD_BITS-1:0] cmd);
      pose_item_type       p;
      logic [SUM_BITS-1:0] diff;
      longint              delta;
      longint              h;
      logic [31:0]         angle;
      longint              sn;
      longint              cs;
      p.updated = 1'b0;
      if (act == ACTION_COMMAND) begin
         motion = cmd;
      end else begin
         sum_now = SUM_BITS'(l) + SUM_BITS'(r);
         diff    = sum_now - sum_base;
         delta   = $signed(diff);
         case (motion)
            CMD_RIGHT: begin
               arc_steps   = delta / 2;
               queued_work = PEND_TURN;
            end
            CMD_LEFT: begin
               arc_steps   = (-delta) / 2;
               queued_work = PEND_TURN;
            end
            CMD_FORWARD: begin
               queued_work = PEND_MOVE;
            end
            default: begin
               // stop: apply whatever is pending
               if (queued_work == PEND_MOVE) begin
                  angle = 32'(heading_idx) << (32 - HEADING_BITS);
                  sn    = angle_sin_q16(angle);
                  cs    = angle_sin_q16(angle + 32'h4000_0000);
                  x_pos = clamp32(x_pos + axis_step(delta, sn, scale));
                  y_pos = clamp32(y_pos + axis_step(delta, cs, scale));
                  queued_work = PEND_NONE;
                  sum_base    = sum_now;
                  p.updated   = 1'b1;
               end else if (queued_work == PEND_TURN) begin
                  h = arc_steps % HEADING_STEPS;
                  if (h < 0) h += HEADING_STEPS;
                  heading_idx = heading_idx + HEADING_BITS'(h);
                  queued_work = PEND_NONE;
                  sum_base    = sum_now;
                  p.updated   = 1'b1;
               end
            end
         endcase
      end
      p.x       = x_pos[POS_BITS-1:0];
      p.y       = y_pos[POS_BITS-1:0];
      p.heading = heading_idx;
      expected_poses.push_back(p);
   endtask

   // Watch the three channels at each rising edge
   always @(posedge clock) begin
      pose_item_type want;
      if (reset) begin
         scale          = MPT_RESET;
         motion         = CMD_STOP;
         queued_work    = PEND_NONE;
         sum_now        = '0;
         sum_base       = '0;
         arc_steps      = 0;
         heading_idx    = '0;
         x_pos          = 0;
         y_pos          = 0;
         mismatch_count = 0;
         expected_poses.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) scale = csr_bus.metres_per_tick;
         if (req_bus.valid && req_bus.ready)
            advance_pose(req_bus.action, req_bus.left_count, req_bus.right_count,
                         req_bus.command);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_poses.size() == 0) begin
               report_mismatch("pose item with none expected", 0, 0);
            end else begin
               want = expected_poses.pop_front();
               if (rsp_bus.pos_x !== want.x)
                  report_mismatch("pos_x", rsp_bus.pos_x, want.x);
               if (rsp_bus.pos_y !== want.y)
                  report_mismatch("pos_y", rsp_bus.pos_y, want.y);
               if (rsp_bus.heading !== want.heading)
                  report_mismatch("heading", rsp_bus.heading, want.heading);
               if (rsp_bus.updated !== want.updated)
                  report_mismatch("updated", rsp_bus.updated, want.updated);
            end
         end
      end
      backlog = expected_poses.size();
   end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top for the odometry unit: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 1ps

module tb_top;
   import ddo_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;
   localparam int PHASE_ITEMS = 200;

   logic clock;
   logic reset;

   ddo_req_if req_bus ();
   ddo_rsp_if rsp_bus ();
   ddo_csr_if csr_bus ();

   int mismatch_count;
   int backlog;
   int snd_idle_pct  = 26;
   int rcv_idle_pct  = 75;
   int hold_requests = 0;
   int phase_items   = 0;
   int quiet_cycles  = 0;

   logic [COUNT_BITS-1:0] left_ticks;
   logic [COUNT_BITS-1:0] right_ticks;

   diff_drive_odometry_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   ddo_pose_checker pose_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_bus        (csr_bus),
      .mismatch_count (mismatch_count),
      .backlog        (backlog)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: random stalls, plus a long hold-off when one is requested
   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("diff_drive_odometry_unit regression: fail");
         $finish;
      end
   end

   // Offer one item, with random idle cycles ahead of it; returns at a falling edge
   task automatic put_item(input logic act, input logic [COUNT_BITS-1:0] l,
                           input logic [COUNT_BITS-1:0] r, input logic [CMD_BITS-1:0] cmd);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.left_count  <= l;
      req_bus.right_count <= r;
      req_bus.command     <= cmd;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      phase_items++;
   endtask

   // Commands carry random count fields, samples a random command field
   task automatic command_item(input logic [CMD_BITS-1:0] cmd);
      put_item(ACTION_COMMAND, COUNT_BITS'($urandom), COUNT_BITS'($urandom), cmd);
   endtask

   task automatic sample_item(input logic [COUNT_BITS-1:0] l, input logic [COUNT_BITS-1:0] r);
      put_item(ACTION_SAMPLE, l, r, CMD_BITS'($urandom));
   endtask

   // Move the wheel counters: mostly small steps, some backward, some jumps
   task automatic roll_wheels();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         left_ticks  = left_ticks + COUNT_BITS'($urandom_range(300));
         right_ticks = right_ticks + COUNT_BITS'($urandom_range(300));
      end else if (pick < 70) begin
         left_ticks  = left_ticks - COUNT_BITS'($urandom_range(300));
         right_ticks = right_ticks - COUNT_BITS'($urandom_range(300));
      end else if (pick < 80) begin
         left_ticks  = left_ticks + COUNT_BITS'($urandom_range(40));
         right_ticks = right_ticks - COUNT_BITS'($urandom_range(40));
      end else if (pick < 90) begin
         left_ticks  = COUNT_BITS'($urandom);
         right_ticks = COUNT_BITS'($urandom);
      end
   endtask

   task automatic roll_and_sample();
      roll_wheels();
      sample_item(left_ticks, right_ticks);
   endtask

   // Drop valid and wait until every pose item has been taken
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (backlog != 0);
   endtask

   task automatic write_scale(input logic [MPT_BITS-1:0] v);
      csr_bus.valid           <= 1'b1;
      csr_bus.metres_per_tick <= v;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Hand-picked items: every command, moves, turns both ways, counter wrap, reverse move
   task automatic directed_items();
      sample_item(24'd0, 24'd0);               // stop with nothing pending
      command_item(CMD_FORWARD);
      sample_item(24'd1000, 24'd1000);
      command_item(CMD_STOP);
      sample_item(24'd1000, 24'd1000);         // move at heading zero
      command_item(CMD_LEFT);
      sample_item(24'd1016, 24'd1000);
      command_item(CMD_STOP);
      sample_item(24'd1016, 24'd1000);         // left turn wraps heading below zero
      command_item(CMD_RIGHT);
      sample_item(24'd1000, 24'd1001);         // odd negative delta, truncation
      command_item(CMD_FORWARD);               // forward replaces the pending turn
      sample_item(24'd1300, 24'd1301);
      command_item(CMD_STOP);
      sample_item(24'd1300, 24'd1301);
      command_item(CMD_FORWARD);
      sample_item(24'hFFFFFF, 24'hFFFFFF);
      command_item(CMD_STOP);
      sample_item(24'hFFFFFF, 24'hFFFFFF);     // sum near the top wraps to a short backward move
      command_item(CMD_RIGHT);
      sample_item(24'd0, 24'd0);               // sum wraps through zero
      command_item(CMD_STOP);
      sample_item(24'd0, 24'd0);
      command_item(CMD_FORWARD);
      sample_item(24'd5, 24'd5);
      command_item(CMD_STOP);
      sample_item(24'hFFFFF0, 24'hFFFFF0);     // move backward
      left_ticks  = 24'hFFFFF0;
      right_ticks = 24'hFFFFF0;
   endtask

   // One short manoeuvre, or now and then a fully random item
   task automatic maneuver();
      int                  pick;
      logic [CMD_BITS-1:0] cmd;
      pick = $urandom_range(99);
      if (pick < 15) begin
         put_item(1'($urandom), COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                  CMD_BITS'($urandom));
      end else begin
         pick = $urandom_range(99);
         cmd  = (pick < 40) ? CMD_FORWARD : (pick < 65) ? CMD_LEFT :
                (pick < 90) ? CMD_RIGHT : CMD_STOP;
         command_item(cmd);
         repeat ($urandom_range(1, 3)) roll_and_sample();
         if ($urandom_range(99) < 20) begin
            command_item(CMD_FORWARD);
            roll_and_sample();
         end
         command_item(CMD_STOP);
         repeat ($urandom_range(1, 2)) roll_and_sample();
      end
   endtask

   // Stimulus: reset, then phases with different scale and idling
   initial begin : stimulus
      logic [MPT_BITS-1:0] scales [4];
      bit                  paused;
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.action          = ACTION_SAMPLE;
      req_bus.left_count      = '0;
      req_bus.right_count     = '0;
      req_bus.command         = CMD_STOP;
      csr_bus.valid           = 1'b0;
      csr_bus.metres_per_tick = '0;
      left_ticks              = '0;
      right_ticks             = '0;
      scales = '{MPT_RESET, {MPT_BITS{1'b1}}, '0, MPT_BITS'($urandom)};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         repeat (12) @(negedge clock);
         write_scale(scales[phase]);
         case (phase)
            0: begin
               snd_idle_pct = 26;
               rcv_idle_pct = 75;
            end
            1: begin
               snd_idle_pct = 75;
               rcv_idle_pct = 26;
            end
            default: begin
               snd_idle_pct = 0;
               rcv_idle_pct = 0;
            end
         endcase
         phase_items = 0;
         paused      = 1'b0;
         if (phase == 0) directed_items();
         if (phase == 2) hold_requests++;   // long result stall while items keep coming
         while (phase_items < PHASE_ITEMS) begin
            if (!paused && phase_items >= PHASE_ITEMS / 2) begin
               wait_drained();
               paused = 1'b1;
            end
            maneuver();
         end
      end

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0 && backlog == 0)
         $display("diff_drive_odometry_unit regression: pass");
      else
         $display("diff_drive_odometry_unit regression: fail");
      $finish;
   end

endmodule

// File: sim.f
src/ddo_pkg.sv
src/ddo_channels.sv
src/diff_drive_odometry_unit.sv
src/ddo_checker.sv
tb/sv/ddo_pose_checker.sv
tb/sv/tb_top.sv
